[sv/pwc_pkg.sv]
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared constants, codes and types of the IR pulse width capture block.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int STORE_DEPTH_DEFAULT = 128;
  localparam int TIMER_BITS_DEFAULT  = 16;

  localparam int ACTION_W = 2;
  localparam int RIDX_W   = 7;
  localparam int WIDTH_W  = 16;
  localparam int COUNT_W  = 8;
  localparam int STATE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESUME = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_LEVEL   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] GAP_LIMIT_RESET = 16'd100;

  typedef struct packed {
    logic               recorded;
    logic [RIDX_W-1:0]  record_index;
    logic [WIDTH_W-1:0] record_width;
    logic [STATE_W-1:0] capture_state;
    logic               ready_res;
    logic [COUNT_W-1:0] entry_count;
    logic               led_on;
    logic               rd_hit;
  } pwc_status_t;

endpackage

[sv/pwc_store.sv]
// ----------------------------------------------------------------------------
// pwc_store
// Width store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pwc_store #(
  parameter int DEPTH  = pwc_pkg::STORE_DEPTH_DEFAULT,
  parameter int DATA_W = pwc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/pwc_ctrl.sv]
// ----------------------------------------------------------------------------
// pwc_ctrl
// Capture sequencer: configuration registers, phase, tick timer and entry
// count, with the store write request for each tick that records a width.
// ----------------------------------------------------------------------------
module pwc_ctrl #(
  parameter int STORE_DEPTH = pwc_pkg::STORE_DEPTH_DEFAULT,
  parameter int TIMER_BITS  = pwc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                fire,
  input  logic [pwc_pkg::ACTION_W-1:0]        action,
  input  logic                                pin_level,
  input  logic [pwc_pkg::RIDX_W-1:0]          read_index,
  output logic                                wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]      wr_addr,
  output logic [TIMER_BITS-1:0]               wr_data,
  output pwc_pkg::pwc_status_t                status
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (TIMER_BITS > pwc_pkg::WIDTH_W) ? TIMER_BITS : pwc_pkg::WIDTH_W;
  localparam int IXW  = (AW > pwc_pkg::RIDX_W) ? AW : pwc_pkg::RIDX_W;
  localparam int ECW  = (CW > pwc_pkg::COUNT_W) ? CW : pwc_pkg::COUNT_W;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  logic [pwc_pkg::CFG_DATA_W-1:0] gap_limit;
  logic                           blink_enable;
  logic                           mark_level;

  phase_t                phase, phase_next, phase_eff;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic [CW-1:0]         count, count_next;
  logic                  led, led_next;

  logic          is_mark;
  logic          full;
  logic          store;
  logic [AW-1:0] store_idx;
  logic          rd_hit;
  logic [CMPW-1:0] timer_cmp, gap_cmp, width_ext;
  logic [IXW-1:0]  idx_ext;
  logic [ECW-1:0]  count_ext;

  assign is_mark   = (pin_level == mark_level);
  assign timer_inc = (timer == {TIMER_BITS{1'b1}}) ? timer : timer + 1'b1;
  assign full      = (count >= CW'(STORE_DEPTH));
  assign phase_eff = full ? PH_STOP : phase;
  assign timer_cmp = CMPW'(timer_inc);
  assign gap_cmp   = CMPW'(gap_limit);

  always_comb begin
    phase_next = phase;
    timer_next = timer;
    count_next = count;
    led_next   = led;
    store      = 1'b0;
    store_idx  = count[AW-1:0];
    rd_hit     = 1'b0;
    unique case (action)
      pwc_pkg::ACT_TICK: begin
        timer_next = timer_inc;
        phase_next = phase_eff;
        unique case (phase_eff)
          PH_IDLE: begin
            if (is_mark) begin
              timer_next = '0;
              if (timer_cmp >= gap_cmp) begin
                store      = 1'b1;
                store_idx  = '0;
                count_next = CW'(1);
                phase_next = PH_MARK;
              end
            end
          end
          PH_MARK: begin
            if (!is_mark) begin
              store      = 1'b1;
              count_next = count + 1'b1;
              timer_next = '0;
              phase_next = PH_SPACE;
            end
          end
          PH_SPACE: begin
            if (is_mark) begin
              store      = 1'b1;
              count_next = count + 1'b1;
              timer_next = '0;
              phase_next = PH_MARK;
            end else if (timer_cmp > gap_cmp) begin
              phase_next = PH_STOP;
            end
          end
          PH_STOP: begin
            if (is_mark) begin
              timer_next = '0;
            end
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase
        if (blink_enable) begin
          led_next = is_mark;
        end
      end
      pwc_pkg::ACT_RESUME: begin
        phase_next = PH_IDLE;
        count_next = '0;
      end
      pwc_pkg::ACT_READ: begin
        rd_hit = (32'(read_index) < 32'(count)) && (32'(read_index) < STORE_DEPTH);
      end
      default: begin
        rd_hit = 1'b0;
      end
    endcase
  end

  assign wr_en   = fire && store;
  assign wr_addr = store_idx;
  assign wr_data = timer_inc;

  assign width_ext = CMPW'(timer_inc);
  assign idx_ext   = IXW'(store_idx);
  assign count_ext = ECW'(count_next);

  always_comb begin
    status               = '0;
    status.recorded      = store;
    status.record_index  = store ? idx_ext[pwc_pkg::RIDX_W-1:0] : '0;
    status.record_width  = store ? width_ext[pwc_pkg::WIDTH_W-1:0] : '0;
    status.capture_state = phase_next;
    status.ready_res     = (phase_next == PH_STOP);
    status.entry_count   = count_ext[pwc_pkg::COUNT_W-1:0];
    status.led_on        = led_next;
    status.rd_hit        = rd_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit    <= pwc_pkg::GAP_LIMIT_RESET;
      blink_enable <= 1'b0;
      mark_level   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwc_pkg::REG_GAP_LIMIT:    gap_limit    <= cfg_data;
        pwc_pkg::REG_BLINK_ENABLE: blink_enable <= cfg_data[0];
        pwc_pkg::REG_MARK_LEVEL:   mark_level   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      timer <= '0;
      count <= '0;
      led   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      timer <= timer_next;
      count <= count_next;
      led   <= led_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  a_write_on_tick: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (fire && action == pwc_pkg::ACT_TICK))
    else $error("store write outside a tick transaction");

  a_resume_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && action == pwc_pkg::ACT_RESUME) |=> (count == '0 && phase == PH_IDLE))
    else $error("resume did not rearm capture");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en)
    else $error("store write while full");

endmodule

[sv/pwc_out.sv]
// ----------------------------------------------------------------------------
// pwc_out
// Result staging: a stage that waits for the store read data, then the
// output register. Accepts a new transaction while stalled only if s1 is empty.
// ----------------------------------------------------------------------------
module pwc_out #(
  parameter int DATA_W = pwc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pwc_pkg::pwc_status_t          status,
  input  logic [DATA_W-1:0]             rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          recorded,
  output logic [pwc_pkg::RIDX_W-1:0]    record_index,
  output logic [pwc_pkg::WIDTH_W-1:0]   record_width,
  output logic [pwc_pkg::STATE_W-1:0]   capture_state,
  output logic                          ready_res,
  output logic [pwc_pkg::COUNT_W-1:0]   entry_count,
  output logic                          led_on,
  output logic [pwc_pkg::WIDTH_W-1:0]   read_data
);

  localparam int DW = (DATA_W > pwc_pkg::WIDTH_W) ? DATA_W : pwc_pkg::WIDTH_W;

  logic                 s1_valid;
  pwc_pkg::pwc_status_t s1_status;
  pwc_pkg::pwc_status_t out_status;
  logic                 s1_adv;
  logic [DW-1:0]        rd_ext;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign rd_ext   = DW'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_status <= status;
    end
    if (s1_adv) begin
      out_status <= s1_status;
      read_data  <= s1_status.rd_hit ? rd_ext[pwc_pkg::WIDTH_W-1:0] : '0;
    end
  end

  assign recorded      = out_status.recorded;
  assign record_index  = out_status.record_index;
  assign record_width  = out_status.record_width;
  assign capture_state = out_status.capture_state;
  assign ready_res     = out_status.ready_res;
  assign entry_count   = out_status.entry_count;
  assign led_on        = out_status.led_on;

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_ready)
    else $error("transaction taken over a stalled stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("staged result lost under stall");

endmodule

[sv/ir_pulse_width_capture.sv]
// ----------------------------------------------------------------------------
// ir_pulse_width_capture
// Raw mark/space width capture for an infrared receiver pin.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one transaction per tick of the
// sampled pin, a resume command or a read of one stored width. Each input
// transaction gives exactly one result on the output channel
// (out_valid/out_ready) with the phase, entry count and LED state after it.
// The result passes the staging stage and then the output register before
// out_valid rises; the block takes one transaction per cycle while the
// receiver does not stall, set by the read-modify-write of the phase/timer
// registers and the one write and one read port of the store.
// A read returns data from the store in the cycle after the address is taken;
// a write of one transaction is visible to a read in the next one.
// Reset (rst, synchronous) puts capture in idle with timer and count at
// zero, the LED off and registers at their defaults; the store contents are
// undefined until written, and entries beyond the count read as zero.
// On a receiver stall the output register holds; in_ready drops at once if
// the staging stage is full, else after one more enters. Configuration writes
// (cfg_we) apply at once and must be made while idle; it is not enforced.
// ----------------------------------------------------------------------------
module ir_pulse_width_capture #(
  parameter int STORE_DEPTH = pwc_pkg::STORE_DEPTH_DEFAULT,
  parameter int TIMER_BITS  = pwc_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pwc_pkg::ACTION_W-1:0]   action,
  input  logic                           pin_level,
  input  logic [pwc_pkg::RIDX_W-1:0]     read_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           recorded,
  output logic [pwc_pkg::RIDX_W-1:0]     record_index,
  output logic [pwc_pkg::WIDTH_W-1:0]    record_width,
  output logic [pwc_pkg::STATE_W-1:0]    capture_state,
  output logic                           ready_res,
  output logic [pwc_pkg::COUNT_W-1:0]    entry_count,
  output logic                           led_on,
  output logic [pwc_pkg::WIDTH_W-1:0]    read_data
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int RXW = (AW > pwc_pkg::RIDX_W) ? AW : pwc_pkg::RIDX_W;

  logic                  fire;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [TIMER_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [RXW-1:0]        rd_addr_ext;
  logic [TIMER_BITS-1:0] rd_data;
  pwc_pkg::pwc_status_t  status;

  assign fire        = in_valid && in_ready;
  assign rd_en       = fire && (action == pwc_pkg::ACT_READ);
  assign rd_addr_ext = RXW'(read_index);

  pwc_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .TIMER_BITS  (TIMER_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .action     (action),
    .pin_level  (pin_level),
    .read_index (read_index),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .status     (status)
  );

  pwc_store #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (TIMER_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  pwc_out #(
    .DATA_W (TIMER_BITS)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .status        (status),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .recorded      (recorded),
    .record_index  (record_index),
    .record_width  (record_width),
    .capture_state (capture_state),
    .ready_res     (ready_res),
    .entry_count   (entry_count),
    .led_on        (led_on),
    .read_data     (read_data)
  );

endmodule
